### hdl/trm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package trm_pkg;

  // Sensor kind codes
  localparam logic [2:0] KIND_NONE    = 3'd0;
  localparam logic [2:0] KIND_WORD    = 3'd1;
  localparam logic [2:0] KIND_UBYTE   = 3'd2;
  localparam logic [2:0] KIND_SBYTE_A = 3'd3;
  localparam logic [2:0] KIND_SBYTE_B = 3'd4;

  // Case read request codes
  localparam logic [1:0] NEXT_BYTE_CH0 = 2'd0;
  localparam logic [1:0] NEXT_WORD_CH1 = 2'd1;
  localparam logic [1:0] NEXT_LOCAL    = 2'd2;
  localparam logic [1:0] NEXT_NONE     = 2'd3;

  // Configuration register indexes
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 13;
  localparam logic [CfgIdxW-1:0] REG_SENSOR_KIND  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_SHOW_CASE    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_USE_FAHR     = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_ALERT_ON     = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_ALERT_CLEAR  = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_CPU_WARN     = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_CASE_WARN    = 3'd6;

  // Threshold reset values, tenths of a degree
  localparam logic signed [12:0] ALERT_ON_RST    = 13'sd850;
  localparam logic signed [12:0] ALERT_CLEAR_RST = 13'sd750;
  localparam logic signed [12:0] CPU_WARN_RST    = 13'sd750;
  localparam logic signed [12:0] CASE_WARN_RST   = 13'sd550;

  // Stream widths
  localparam int InDataW  = 32;
  localparam int InUserW  = 2;
  localparam int OutDataW = 56;
  localparam int OutUserW = 5;

  // Case source probe sequence
  typedef enum logic [4:0] {
    PROBE_UNKNOWN  = 5'b00001,
    PROBE_TRY_CH1  = 5'b00010,
    PROBE_BYTE_CH0 = 5'b00100,
    PROBE_WORD_CH1 = 5'b01000,
    PROBE_ABSENT   = 5'b10000
  } trm_probe_e;

  typedef struct packed {
    logic [2:0]        sensor_kind;
    logic              show_case;
    logic              use_fahrenheit;
    logic signed [12:0] alert_on;
    logic signed [12:0] alert_clear;
    logic signed [12:0] cpu_warn;
    logic signed [12:0] case_warn;
  } trm_cfg_t;

  typedef struct packed {
    logic        cpu_ok;
    logic [15:0] cpu_raw;
    logic        case_ok;
    logic [15:0] case_raw;
  } trm_item_t;

  // Result fields after the state update, display still before the final /10
  typedef struct packed {
    logic signed [12:0] cpu_tenths;
    logic signed [12:0] case_tenths;
    logic signed [12:0] peak_tenths;
    logic               have_cpu;
    logic               have_case;
    logic               alert_fire;
    logic               alert_active;
    logic               display_red;
    logic [1:0]         next_case_read;
    logic signed [13:0] disp_pre;
  } trm_res_t;

  // Two-byte reading: (signed word * 10) / 256, truncated toward zero
  function automatic logic signed [12:0] dec_word(input logic [15:0] raw);
    logic signed [19:0] x;
    logic signed [19:0] p;
    logic signed [19:0] adj;
    x   = 20'(signed'(raw));
    p   = (x <<< 3) + (x <<< 1);
    adj = p + (p[19] ? 20'sd255 : 20'sd0);
    return 13'(adj >>> 8);
  endfunction

  // Signed byte times ten
  function automatic logic signed [12:0] dec_sbyte(input logic [7:0] raw);
    logic signed [12:0] x;
    x = 13'(signed'(raw));
    return (x <<< 3) + (x <<< 1);
  endfunction

  // Unsigned byte times ten
  function automatic logic signed [12:0] dec_ubyte(input logic [7:0] raw);
    logic signed [12:0] x;
    x = signed'({5'd0, raw});
    return (x <<< 3) + (x <<< 1);
  endfunction

endpackage

`default_nettype wire

### hdl/trm_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module trm_cfg_regs
  import trm_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  output trm_cfg_t                 cfg_o
);

  trm_cfg_t cfg_q, cfg_d;

  // Register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SENSOR_KIND: cfg_d.sensor_kind    = cfg_data_i[2:0];
        REG_SHOW_CASE:   cfg_d.show_case      = cfg_data_i[0];
        REG_USE_FAHR:    cfg_d.use_fahrenheit = cfg_data_i[0];
        REG_ALERT_ON:    cfg_d.alert_on       = signed'(cfg_data_i);
        REG_ALERT_CLEAR: cfg_d.alert_clear    = signed'(cfg_data_i);
        REG_CPU_WARN:    cfg_d.cpu_warn       = signed'(cfg_data_i);
        REG_CASE_WARN:   cfg_d.case_warn      = signed'(cfg_data_i);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sensor_kind    <= KIND_NONE;
      cfg_q.show_case      <= 1'b0;
      cfg_q.use_fahrenheit <= 1'b0;
      cfg_q.alert_on       <= ALERT_ON_RST;
      cfg_q.alert_clear    <= ALERT_CLEAR_RST;
      cfg_q.cpu_warn       <= CPU_WARN_RST;
      cfg_q.case_warn      <= CASE_WARN_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

### hdl/trm_track.sv
`timescale 1ns / 1ps
`default_nettype none

module trm_track
  import trm_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  trm_cfg_t  cfg_i,
  input  wire logic upd_i,
  input  trm_item_t item_i,
  output trm_res_t  res_o
);

  // x / 5 truncated toward zero: |x| * 52429 >> 18, exact for |x| < 52428
  localparam logic [15:0] Div5Mul = 16'd52429;

  function automatic logic signed [13:0] div5(input logic signed [16:0] a);
    logic [15:0] mag;
    logic [31:0] prod;
    logic [13:0] q;
    mag  = a[16] ? 16'(-a) : a[15:0];
    prod = 32'(mag) * 32'(Div5Mul);
    q    = prod[31:18];
    return a[16] ? -signed'(q) : signed'(q);
  endfunction

  logic signed [12:0] cpu_val_q, cpu_val_d;
  logic signed [12:0] case_val_q, case_val_d;
  logic signed [12:0] peak_q, peak_d;
  logic               cpu_seen_q, cpu_seen_d;
  logic               case_seen_q, case_seen_d;
  logic               peak_vld_q, peak_vld_d;
  logic               latch_q, latch_d;
  trm_probe_e         probe_q, probe_d;

  logic               fire;
  logic               active;
  logic [1:0]         next_rd;
  logic signed [12:0] sel;
  logic signed [16:0] sel9;
  logic signed [13:0] q5;
  logic               red;

  // Decode, probe sequence, peak and alert hysteresis
  always_comb begin
    cpu_val_d   = cpu_val_q;
    case_val_d  = case_val_q;
    peak_d      = peak_q;
    cpu_seen_d  = cpu_seen_q;
    case_seen_d = case_seen_q;
    peak_vld_d  = peak_vld_q;
    latch_d     = latch_q;
    probe_d     = probe_q;
    fire        = 1'b0;
    active      = 1'b1;
    next_rd     = NEXT_NONE;

    case (cfg_i.sensor_kind)
      KIND_WORD: begin
        if (item_i.cpu_ok) begin
          cpu_val_d  = dec_word(item_i.cpu_raw);
          cpu_seen_d = 1'b1;
        end
        case (probe_q)
          PROBE_UNKNOWN: begin
            if (item_i.case_ok) begin
              case_val_d  = dec_sbyte(item_i.case_raw[7:0]);
              case_seen_d = 1'b1;
              probe_d     = PROBE_BYTE_CH0;
            end else begin
              case_seen_d = 1'b0;
              probe_d     = PROBE_TRY_CH1;
            end
          end
          PROBE_TRY_CH1: begin
            if (item_i.case_ok) begin
              case_val_d  = dec_word(item_i.case_raw);
              case_seen_d = 1'b1;
              probe_d     = PROBE_WORD_CH1;
            end else begin
              case_seen_d = 1'b0;
              probe_d     = PROBE_ABSENT;
            end
          end
          PROBE_BYTE_CH0: begin
            if (item_i.case_ok) begin
              case_val_d  = dec_sbyte(item_i.case_raw[7:0]);
              case_seen_d = 1'b1;
            end else begin
              case_seen_d = 1'b0;
            end
          end
          PROBE_WORD_CH1: begin
            if (item_i.case_ok) begin
              case_val_d  = dec_word(item_i.case_raw);
              case_seen_d = 1'b1;
            end else begin
              case_seen_d = 1'b0;
            end
          end
          default: case_seen_d = 1'b0;
        endcase
        case (probe_d)
          PROBE_UNKNOWN, PROBE_BYTE_CH0: next_rd = NEXT_BYTE_CH0;
          PROBE_TRY_CH1, PROBE_WORD_CH1: next_rd = NEXT_WORD_CH1;
          default:                       next_rd = NEXT_NONE;
        endcase
      end
      KIND_UBYTE: begin
        if (item_i.cpu_ok) begin
          cpu_val_d  = dec_ubyte(item_i.cpu_raw[7:0]);
          cpu_seen_d = 1'b1;
        end
        if (item_i.case_ok) begin
          case_val_d = dec_ubyte(item_i.case_raw[7:0]);
        end
        case_seen_d = item_i.case_ok;
        next_rd     = NEXT_LOCAL;
      end
      KIND_SBYTE_A, KIND_SBYTE_B: begin
        if (item_i.cpu_ok) begin
          cpu_val_d  = dec_sbyte(item_i.cpu_raw[7:0]);
          cpu_seen_d = 1'b1;
        end
        if (item_i.case_ok) begin
          case_val_d = dec_sbyte(item_i.case_raw[7:0]);
        end
        case_seen_d = item_i.case_ok;
        next_rd     = NEXT_LOCAL;
      end
      default: active = 1'b0;
    endcase

    if (active && cpu_seen_d) begin
      if (!peak_vld_q || (cpu_val_d > peak_q)) begin
        peak_d     = cpu_val_d;
        peak_vld_d = 1'b1;
      end
      if (cpu_val_d >= cfg_i.alert_on) begin
        if (!latch_q) begin
          latch_d = 1'b1;
          fire    = 1'b1;
        end
      end else if (cpu_val_d < cfg_i.alert_clear) begin
        latch_d = 1'b0;
      end
    end
  end

  // Display select; Fahrenheit takes x * 9 / 5 here, the final /10 comes later
  always_comb begin
    sel  = cfg_i.show_case ? case_val_d : cpu_val_d;
    sel9 = (17'(sel) <<< 3) + 17'(sel);
    q5   = div5(sel9);
    if (cfg_i.show_case) begin
      red = case_seen_d && (case_val_d >= cfg_i.case_warn);
    end else begin
      red = cpu_seen_d && (cpu_val_d >= cfg_i.cpu_warn);
    end
  end

  always_comb begin
    res_o.cpu_tenths     = cpu_val_d;
    res_o.case_tenths    = case_val_d;
    res_o.peak_tenths    = peak_vld_d ? peak_d : 13'sd0;
    res_o.have_cpu       = cpu_seen_d;
    res_o.have_case      = case_seen_d;
    res_o.alert_fire     = fire;
    res_o.alert_active   = latch_d;
    res_o.display_red    = red;
    res_o.next_case_read = next_rd;
    res_o.disp_pre       = cfg_i.use_fahrenheit ? (q5 + 14'sd325) : (14'(sel) + 14'sd5);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpu_val_q   <= '0;
      case_val_q  <= '0;
      peak_q      <= '0;
      cpu_seen_q  <= 1'b0;
      case_seen_q <= 1'b0;
      peak_vld_q  <= 1'b0;
      latch_q     <= 1'b0;
      probe_q     <= PROBE_UNKNOWN;
    end else if (upd_i) begin
      cpu_val_q   <= cpu_val_d;
      case_val_q  <= case_val_d;
      peak_q      <= peak_d;
      cpu_seen_q  <= cpu_seen_d;
      case_seen_q <= case_seen_d;
      peak_vld_q  <= peak_vld_d;
      latch_q     <= latch_d;
      probe_q     <= probe_d;
    end
  end

endmodule

`default_nettype wire

### hdl/trm_div10.sv
`timescale 1ns / 1ps
`default_nettype none

module trm_div10
  import trm_pkg::*;
(
  input  wire logic signed [13:0] pre_i,
  output logic signed [9:0]       disp_o
);

  // |x| * 52429 >> 19 equals |x| / 10 for |x| below 26214
  localparam logic [15:0] Div10Mul = 16'd52429;

  logic [13:0]        mag;
  logic [29:0]        prod;
  logic [10:0]        quo;
  logic signed [10:0] res;

  // Truncating divide by ten, sign restored afterwards
  always_comb begin
    mag    = pre_i[13] ? 14'(-pre_i) : pre_i[13:0];
    prod   = 30'(mag) * 30'(Div10Mul);
    quo    = prod[29:19];
    res    = pre_i[13] ? -signed'(quo) : signed'(quo);
    disp_o = res[9:0];
  end

endmodule

`default_nettype wire

### hdl/thermal_reading_monitor_core.sv
`timescale 1ns / 1ps
`default_nettype none
// A result passes the input register, the state-update register and the output register
// before it is presented on the master side. Throughput: one transfer per cycle; these
// registers form a three-deep pipeline stalled only by m_axis_tready.
// Reset (rst_ni low, asynchronous): pipeline empty, readings, flags, peak and alert
// cleared, probe sequence back to unknown source, configuration at its defaults.

module thermal_reading_monitor_core
  import trm_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // Configuration writes
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  // Input stream
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // [15:0] cpu_raw, [31:16] case_raw
  input  wire logic [InDataW-1:0]  s_axis_tdata,
  // [0] cpu_ok, [1] case_ok
  input  wire logic [InUserW-1:0]  s_axis_tuser,
  // Result stream
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // [12:0] cpu_tenths, [25:13] case_tenths, [38:26] peak_tenths,
  // [48:39] display_value, [50:49] next_case_read, [55:51] zero
  output logic [OutDataW-1:0]      m_axis_tdata,
  // [0] have_cpu, [1] have_case, [2] alert_fire, [3] alert_active, [4] display_red
  output logic [OutUserW-1:0]      m_axis_tuser
);

  trm_cfg_t  cfg;
  trm_item_t in_q;
  logic      in_vld_q;
  trm_res_t  res;
  trm_res_t  mid_q;
  logic      mid_vld_q;
  logic      out_vld_q;
  logic [OutDataW-1:0] out_data_q;
  logic [OutUserW-1:0] out_user_q;
  logic signed [9:0]   disp;

  logic in_xfer;
  logic upd;
  logic mid_free;
  logic ld_out;

  trm_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Pipeline flow control
  assign ld_out        = mid_vld_q && (!out_vld_q || m_axis_tready);
  assign mid_free      = !mid_vld_q || ld_out;
  assign upd           = in_vld_q && mid_free;
  assign s_axis_tready = !in_vld_q || upd;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      mid_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        in_vld_q <= 1'b1;
      end else if (upd) begin
        in_vld_q <= 1'b0;
      end
      if (upd) begin
        mid_vld_q <= 1'b1;
      end else if (ld_out) begin
        mid_vld_q <= 1'b0;
      end
      if (ld_out) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Input register
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_q.cpu_ok   <= s_axis_tuser[0];
      in_q.case_ok  <= s_axis_tuser[1];
      in_q.cpu_raw  <= s_axis_tdata[15:0];
      in_q.case_raw <= s_axis_tdata[31:16];
    end
  end

  trm_track u_track (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .upd_i  (upd),
    .item_i (in_q),
    .res_o  (res)
  );

  // Post-update result register
  always_ff @(posedge clk_i) begin
    if (upd) begin
      mid_q <= res;
    end
  end

  trm_div10 u_div10 (
    .pre_i  (mid_q.disp_pre),
    .disp_o (disp)
  );

  // Output register
  always_ff @(posedge clk_i) begin
    if (ld_out) begin
      out_data_q <= {5'd0, mid_q.next_case_read, disp, mid_q.peak_tenths,
                     mid_q.case_tenths, mid_q.cpu_tenths};
      out_user_q <= {mid_q.display_red, mid_q.alert_active, mid_q.alert_fire,
                     mid_q.have_case, mid_q.have_cpu};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

`default_nettype wire

### bench/thermal_reading_monitor_core_tb.sv
`timescale 1ns / 1ps

module thermal_reading_monitor_core_tb;
  import trm_pkg::*;

  // Cycles without any transfer before the run is declared hung
  localparam int StallLimit = 2000;
  // Index with no register behind it; writes to it must change nothing
  localparam logic [CfgIdxW-1:0] REG_SPARE = 3'd7;

  typedef struct packed {
    logic signed [12:0] cpu_tenths;
    logic signed [12:0] case_tenths;
    logic signed [12:0] peak_tenths;
    logic signed [9:0]  display_value;
    logic [1:0]         next_case_read;
    logic               have_cpu;
    logic               have_case;
    logic               alert_fire;
    logic               alert_active;
    logic               display_red;
  } reading_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  // [15:0] cpu_raw, [31:16] case_raw
  logic [InDataW-1:0]  s_axis_tdata = '0;
  // [0] cpu_ok, [1] case_ok
  logic [InUserW-1:0]  s_axis_tuser = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // [12:0] cpu_tenths, [25:13] case_tenths, [38:26] peak_tenths,
  // [48:39] display_value, [50:49] next_case_read, [55:51] zero
  logic [OutDataW-1:0] m_axis_tdata;
  // [0] have_cpu, [1] have_case, [2] alert_fire, [3] alert_active, [4] display_red
  logic [OutUserW-1:0] m_axis_tuser;

  trm_item_t pending_reads[$];
  reading_t  expected_readings[$];
  trm_item_t drive_read;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  int        mismatches = 0;
  int        stall_cycles = 0;

  // Predictor copy of the configuration
  logic [2:0]         kind_cfg;
  logic               show_case_cfg;
  logic               fahr_cfg;
  logic signed [12:0] alert_on_cfg;
  logic signed [12:0] alert_clear_cfg;
  logic signed [12:0] cpu_warn_cfg;
  logic signed [12:0] case_warn_cfg;

  // Predictor copy of the monitor state
  logic signed [12:0] cpu_val;
  logic signed [12:0] case_val;
  logic signed [12:0] peak_val;
  logic               cpu_have;
  logic               case_have;
  logic               peak_held;
  logic               alert_latched;
  trm_probe_e         probe;

  thermal_reading_monitor_core u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Sensor decoders, tenths of a degree
  function automatic logic signed [12:0] word_tenths(input logic [15:0] raw);
    int v;
    v = $signed(raw);
    return 13'((v * 10) / 256);
  endfunction

  function automatic logic signed [12:0] sbyte_tenths(input logic [7:0] raw);
    int v;
    v = $signed(raw);
    return 13'(v * 10);
  endfunction

  function automatic logic signed [12:0] ubyte_tenths(input logic [7:0] raw);
    int v;
    v = raw;
    return 13'(v * 10);
  endfunction

  // Advance the predicted state by one tick and return the expected result
  function automatic reading_t track_reading(input trm_item_t rd);
    reading_t r;
    int       x;
    int       disp;
    logic     active;
    r = '0;
    r.next_case_read = NEXT_NONE;
    active = (kind_cfg >= KIND_WORD) && (kind_cfg <= KIND_SBYTE_B);
    case (kind_cfg)
      KIND_WORD: begin
        if (rd.cpu_ok) begin
          cpu_val = word_tenths(rd.cpu_raw);
          cpu_have = 1'b1;
        end
        // Case source probe
        case (probe)
          PROBE_UNKNOWN: begin
            if (rd.case_ok) begin
              case_val = sbyte_tenths(rd.case_raw[7:0]);
              case_have = 1'b1;
              probe = PROBE_BYTE_CH0;
            end else begin
              case_have = 1'b0;
              probe = PROBE_TRY_CH1;
            end
          end
          PROBE_TRY_CH1: begin
            if (rd.case_ok) begin
              case_val = word_tenths(rd.case_raw);
              case_have = 1'b1;
              probe = PROBE_WORD_CH1;
            end else begin
              case_have = 1'b0;
              probe = PROBE_ABSENT;
            end
          end
          PROBE_BYTE_CH0: begin
            if (rd.case_ok) case_val = sbyte_tenths(rd.case_raw[7:0]);
            case_have = rd.case_ok;
          end
          PROBE_WORD_CH1: begin
            if (rd.case_ok) case_val = word_tenths(rd.case_raw);
            case_have = rd.case_ok;
          end
          default: case_have = 1'b0;
        endcase
        case (probe)
          PROBE_UNKNOWN, PROBE_BYTE_CH0: r.next_case_read = NEXT_BYTE_CH0;
          PROBE_TRY_CH1, PROBE_WORD_CH1: r.next_case_read = NEXT_WORD_CH1;
          default: r.next_case_read = NEXT_NONE;
        endcase
      end
      KIND_UBYTE: begin
        if (rd.cpu_ok) begin
          cpu_val = ubyte_tenths(rd.cpu_raw[7:0]);
          cpu_have = 1'b1;
        end
        if (rd.case_ok) case_val = ubyte_tenths(rd.case_raw[7:0]);
        case_have = rd.case_ok;
        r.next_case_read = NEXT_LOCAL;
      end
      KIND_SBYTE_A, KIND_SBYTE_B: begin
        if (rd.cpu_ok) begin
          cpu_val = sbyte_tenths(rd.cpu_raw[7:0]);
          cpu_have = 1'b1;
        end
        if (rd.case_ok) case_val = sbyte_tenths(rd.case_raw[7:0]);
        case_have = rd.case_ok;
        r.next_case_read = NEXT_LOCAL;
      end
      default: ;
    endcase

    // Peak tracking and alert latch with hysteresis
    if (active && cpu_have) begin
      if (!peak_held || cpu_val > peak_val) begin
        peak_val = cpu_val;
        peak_held = 1'b1;
      end
      if (cpu_val >= alert_on_cfg) begin
        if (!alert_latched) begin
          alert_latched = 1'b1;
          r.alert_fire = 1'b1;
        end
      end else if (cpu_val < alert_clear_cfg) begin
        alert_latched = 1'b0;
      end
    end

    // Display value, truncating divisions
    x = show_case_cfg ? case_val : cpu_val;
    if (fahr_cfg) disp = (x * 9 / 5 + 320 + 5) / 10;
    else disp = (x + 5) / 10;
    if (show_case_cfg) r.display_red = case_have && (case_val >= case_warn_cfg);
    else r.display_red = cpu_have && (cpu_val >= cpu_warn_cfg);

    r.cpu_tenths = cpu_val;
    r.case_tenths = case_val;
    r.peak_tenths = peak_held ? peak_val : 13'sd0;
    r.display_value = 10'(disp);
    r.have_cpu = cpu_have;
    r.have_case = case_have;
    r.alert_active = alert_latched;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < 100) $display("%0t ns: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %h want %h", name, got, want));
  endtask

  task automatic compare_reading(input reading_t want);
    reading_t got;
    got.cpu_tenths = m_axis_tdata[12:0];
    got.case_tenths = m_axis_tdata[25:13];
    got.peak_tenths = m_axis_tdata[38:26];
    got.display_value = m_axis_tdata[48:39];
    got.next_case_read = m_axis_tdata[50:49];
    got.have_cpu = m_axis_tuser[0];
    got.have_case = m_axis_tuser[1];
    got.alert_fire = m_axis_tuser[2];
    got.alert_active = m_axis_tuser[3];
    got.display_red = m_axis_tuser[4];
    check_field("cpu_tenths", got.cpu_tenths, want.cpu_tenths);
    check_field("case_tenths", got.case_tenths, want.case_tenths);
    check_field("peak_tenths", got.peak_tenths, want.peak_tenths);
    check_field("display_value", got.display_value, want.display_value);
    check_field("next_case_read", got.next_case_read, want.next_case_read);
    check_field("have_cpu", got.have_cpu, want.have_cpu);
    check_field("have_case", got.have_case, want.have_case);
    check_field("alert_fire", got.alert_fire, want.alert_fire);
    check_field("alert_active", got.alert_active, want.alert_active);
    check_field("display_red", got.display_red, want.display_red);
    check_field("tdata pad", m_axis_tdata[55:51], 16'd0);
  endtask

  // One register write; caller stands at a rising edge
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    case (idx)
      REG_SENSOR_KIND: kind_cfg = data[2:0];
      REG_SHOW_CASE:   show_case_cfg = data[0];
      REG_USE_FAHR:    fahr_cfg = data[0];
      REG_ALERT_ON:    alert_on_cfg = data;
      REG_ALERT_CLEAR: alert_clear_cfg = data;
      REG_CPU_WARN:    cpu_warn_cfg = data;
      REG_CASE_WARN:   case_warn_cfg = data;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Program every register; noisy sets unused upper data bits and hits the spare index
  task automatic program_monitor(input logic [2:0] kind, input logic show, input logic fahr,
                                 input int on, input int clr, input int cwarn,
                                 input int kwarn, input bit noisy);
    int junk;
    junk = noisy ? $urandom : 0;
    write_reg(REG_SENSOR_KIND, {junk[9:0], kind});
    write_reg(REG_SHOW_CASE, {junk[22:11], show});
    write_reg(REG_USE_FAHR, {junk[31:20], fahr});
    write_reg(REG_ALERT_ON, 13'(on));
    write_reg(REG_ALERT_CLEAR, 13'(clr));
    write_reg(REG_CPU_WARN, 13'(cwarn));
    write_reg(REG_CASE_WARN, 13'(kwarn));
    if (noisy) write_reg(REG_SPARE, 13'($urandom));
    cfg_we_i <= 1'b0;
  endtask

  task automatic send(input logic cpu_ok, input logic [15:0] cpu_raw,
                      input logic case_ok, input logic [15:0] case_raw);
    pending_reads.push_back({cpu_ok, cpu_raw, case_ok, case_raw});
  endtask

  // Wait until every queued read is transferred and every result checked;
  // sampled on the falling edge so the driver's updates have settled
  task automatic drain();
    while (pending_reads.size() != 0 || s_axis_tvalid || expected_readings.size() != 0)
      @(negedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Raw bytes that decode close to a given temperature
  function automatic logic [15:0] raw_near(input int target, input bit word);
    int jitter;
    if (word) begin
      jitter = $urandom_range(60);
      return 16'(target * 256 / 10 + jitter - 30);
    end
    jitter = $urandom_range(6);
    return {8'($urandom), 8'(target / 10 + jitter - 3)};
  endfunction

  // Random ticks, most of them hovering around the thresholds
  task automatic queue_random_reads(input int n);
    trm_item_t rd;
    bit        word_case;
    int        target;
    word_case = (kind_cfg == KIND_WORD) && (probe != PROBE_BYTE_CH0);
    repeat (n) begin
      rd.cpu_ok = $urandom_range(99) < 85;
      rd.case_ok = $urandom_range(99) < 80;
      case ($urandom_range(3))
        0: target = alert_on_cfg;
        1: target = alert_clear_cfg;
        2: target = cpu_warn_cfg;
        default: target = peak_val;
      endcase
      rd.cpu_raw = ($urandom_range(99) < 65) ? raw_near(target, kind_cfg == KIND_WORD)
                                             : 16'($urandom);
      rd.case_raw = ($urandom_range(99) < 65) ? raw_near(case_warn_cfg, word_case)
                                              : 16'($urandom);
      pending_reads.push_back(rd);
    end
  endtask

  // Input side: predict on each transfer, then offer the next queued read
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_readings.push_back(track_reading({s_axis_tuser[0], s_axis_tdata[15:0],
                                                   s_axis_tuser[1], s_axis_tdata[31:16]}));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_reads.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          drive_read = pending_reads.pop_front();
          s_axis_tdata <= {drive_read.case_raw, drive_read.cpu_raw};
          s_axis_tuser <= {drive_read.case_ok, drive_read.cpu_ok};
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result side: check each transfer against the oldest expectation
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_readings.size() == 0) report_mismatch("result with nothing expected");
        else compare_reading(expected_readings.pop_front());
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Hang detection
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
        $display("thermal_reading_monitor_core_tb failed");
        $finish;
      end
    end
  end

  initial begin
    int         p;
    int         on;
    int         clr;
    int         cwarn;
    int         kwarn;
    logic [2:0] phase_kind;

    // Predictor at its reset values
    kind_cfg = KIND_NONE;
    show_case_cfg = 1'b0;
    fahr_cfg = 1'b0;
    alert_on_cfg = ALERT_ON_RST;
    alert_clear_cfg = ALERT_CLEAR_RST;
    cpu_warn_cfg = CPU_WARN_RST;
    case_warn_cfg = CASE_WARN_RST;
    cpu_val = '0;
    case_val = '0;
    peak_val = '0;
    cpu_have = 1'b0;
    case_have = 1'b0;
    peak_held = 1'b0;
    alert_latched = 1'b0;
    probe = PROBE_UNKNOWN;
    send_idle_pct = 30;
    recv_idle_pct = 67;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Two-byte sensor: probe path chosen at random, word extremes, alert hysteresis
    program_monitor(KIND_WORD, 1'b0, 1'b0, ALERT_ON_RST, ALERT_CLEAR_RST,
                    CPU_WARN_RST, CASE_WARN_RST, 1'b0);
    send(1'b0, 16'hFFFF, 1'($urandom_range(1)), 16'hFF80);
    send(1'b1, 16'h7FFF, 1'($urandom_range(1)), 16'h7FFF);
    send(1'b1, 16'h8000, 1'b1, 16'h8000);
    send(1'b1, 16'hFFFF, 1'b1, 16'hFFFF);
    send(1'b1, 16'h0001, 1'b1, 16'h0000);
    send(1'b1, 16'hFF00, 1'b0, 16'h1234);
    send(1'b1, 16'h5500, 1'b1, 16'h3700);
    send(1'b1, 16'h5500, 1'b1, 16'h3780);
    send(1'b1, 16'h4B00, 1'b1, 16'h007F);
    send(1'b1, 16'h4AFF, 1'b1, 16'h0080);
    send(1'b1, 16'h5600, 1'b1, 16'h3700);
    send(1'b0, 16'h0000, 1'b0, 16'h0000);
    drain();

    // Unsigned bytes, case shown in Fahrenheit
    program_monitor(KIND_UBYTE, 1'b1, 1'b1, ALERT_ON_RST, ALERT_CLEAR_RST,
                    CPU_WARN_RST, CASE_WARN_RST, 1'b0);
    send(1'b1, 16'hFF00, 1'b1, 16'h00FF);
    send(1'b1, 16'h00FF, 1'b1, 16'hFF00);
    send(1'b0, 16'h00FF, 1'b0, 16'h00FF);
    drain();

    // Signed bytes, both codes
    program_monitor(KIND_SBYTE_A, 1'b0, 1'b1, ALERT_ON_RST, ALERT_CLEAR_RST,
                    CPU_WARN_RST, CASE_WARN_RST, 1'b0);
    send(1'b1, 16'h0080, 1'b1, 16'h007F);
    send(1'b1, 16'h007F, 1'b1, 16'h0080);
    drain();
    program_monitor(KIND_SBYTE_B, 1'b1, 1'b0, ALERT_ON_RST, ALERT_CLEAR_RST,
                    CPU_WARN_RST, CASE_WARN_RST, 1'b0);
    send(1'b1, 16'h00FF, 1'b1, 16'hFF80);
    drain();

    // No sensor, and the unused kind codes behave the same way
    for (p = 0; p < 4; p++) begin
      phase_kind = (p == 0) ? KIND_NONE : 3'(KIND_SBYTE_B + p);
      program_monitor(phase_kind, 1'(p), 1'(p >> 1), ALERT_ON_RST, ALERT_CLEAR_RST,
                      CPU_WARN_RST, CASE_WARN_RST, 1'b0);
      send(1'b1, 16'h5500, 1'b1, 16'h5555);
      drain();
    end

    // Random phases, idling first on both sides, swapped, then none
    for (p = 0; p < 9; p++) begin
      send_idle_pct = (p < 3) ? 30 : (p < 6) ? 67 : 0;
      recv_idle_pct = (p < 3) ? 67 : (p < 6) ? 30 : 0;
      if (p % 2 == 0) phase_kind = KIND_WORD;
      else if (p == 1 || p == 7) phase_kind = KIND_UBYTE;
      else if (p == 3) phase_kind = KIND_SBYTE_A;
      else phase_kind = KIND_SBYTE_B;
      case (p)
        2: begin
          on = -1280; clr = -1280; cwarn = -1280; kwarn = -1280;
        end
        5: begin
          on = 2550; clr = 2550; cwarn = 2550; kwarn = 2550;
        end
        7: begin
          on = 4095; clr = -4096; cwarn = -4096; kwarn = 4095;
        end
        default: begin
          on = int'($urandom_range(2400)) - 600;
          clr = on - int'($urandom_range(300));
          cwarn = int'($urandom_range(3830)) - 1280;
          kwarn = int'($urandom_range(3830)) - 1280;
        end
      endcase
      program_monitor(phase_kind, 1'($urandom_range(1)), 1'($urandom_range(1)),
                      on, clr, cwarn, kwarn, 1'b1);
      queue_random_reads(210);
      drain();
    end

    if (expected_readings.size() != 0) report_mismatch("results never arrived");
    if (mismatches == 0) begin
      $display("thermal_reading_monitor_core_tb passed");
    end else begin
      $display("thermal_reading_monitor_core_tb failed");
    end
    $finish;
  end

endmodule

### thermal_reading_monitor_core.f
hdl/trm_pkg.sv
hdl/trm_cfg_regs.sv
hdl/trm_track.sv
hdl/trm_div10.sv
hdl/thermal_reading_monitor_core.sv
bench/thermal_reading_monitor_core_tb.sv
